/* hw/rtl/jsv_pkg.sv */
`default_nettype none

package jsv_pkg;

    typedef enum logic [11:0] {
        PH_LEAD     = 12'b0000_0000_0001,
        PH_LITERAL  = 12'b0000_0000_0010,
        PH_MINUS    = 12'b0000_0000_0100,
        PH_ZERO     = 12'b0000_0000_1000,
        PH_INT      = 12'b0000_0001_0000,
        PH_DOT      = 12'b0000_0010_0000,
        PH_FRAC     = 12'b0000_0100_0000,
        PH_EXP      = 12'b0000_1000_0000,
        PH_EXP_SIGN = 12'b0001_0000_0000,
        PH_EXP_DIG  = 12'b0010_0000_0000,
        PH_TRAIL    = 12'b0100_0000_0000,
        PH_ERROR    = 12'b1000_0000_0000
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EXPECT   = 2'd1,
        ST_INVALID  = 2'd2,
        ST_NOT_SING = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        TY_NULL   = 2'd0,
        TY_FALSE  = 2'd1,
        TY_TRUE   = 2'd2,
        TY_NUMBER = 2'd3
    } t_value_type;

    typedef struct packed {
        t_phase      phase;
        logic [1:0]  lit_kind;
        logic [2:0]  lit_pos;
        t_status     status;
        t_value_type found_type;
    } t_scan_state;

    localparam t_scan_state SCAN_RESET = '{
        phase:      PH_LEAD,
        lit_kind:   TY_NULL,
        lit_pos:    3'd0,
        status:     ST_OK,
        found_type: TY_NULL
    };

    function automatic logic [2:0] lit_len(input logic [1:0] kind);
        logic [2:0] len;
        case (kind)
            TY_FALSE: len = 3'd5;
            default:  len = 3'd4;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (kind)
            TY_FALSE: begin
                case (pos)
                    3'd0:    c = "f";
                    3'd1:    c = "a";
                    3'd2:    c = "l";
                    3'd3:    c = "s";
                    3'd4:    c = "e";
                    default: c = 8'h00;
                endcase
            end
            TY_TRUE: begin
                case (pos)
                    3'd0:    c = "t";
                    3'd1:    c = "r";
                    3'd2:    c = "u";
                    3'd3:    c = "e";
                    default: c = 8'h00;
                endcase
            end
            default: begin
                case (pos)
                    3'd0:    c = "n";
                    3'd1:    c = "u";
                    3'd2:    c = "l";
                    3'd3:    c = "l";
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/json_scalar_validator_unit.sv */
// channel  direction  handshake           payload
// input    in         i_valid / o_ready   i_text_byte[7:0], i_end_of_text
// output   out        o_valid / i_ready   o_status[1:0], o_value_type[1:0]
//
// one item per cycle; an item is registered, scanned in the next cycle and,
// if it is an end marker, its result is in the output register at the end of that cycle
// only an end-marker item waits, while the output register is full and not read;
// the input is held for as long as it waits, otherwise nothing stalls
// synchronous active-low reset empties both registers and returns the scan to
// leading whitespace

`default_nettype none

module json_scalar_validator_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output wire logic       o_ready,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_end_of_text,
    output wire logic       o_valid,
    input  wire logic       i_ready,
    output wire logic [1:0] o_status,
    output wire logic [1:0] o_value_type
);

    logic                 r_in_valid;
    logic [7:0]           r_byte;
    logic                 r_eot;
    jsv_pkg::t_scan_state r_state;
    jsv_pkg::t_scan_state n_state;
    logic                 r_out_valid;
    jsv_pkg::t_status     r_status;
    jsv_pkg::t_status     n_status;
    jsv_pkg::t_value_type r_type;
    jsv_pkg::t_value_type n_type;
    logic                 proc_go;

    jsv_scan u_scan (
        .i_state       (r_state),
        .i_text_byte   (r_byte),
        .i_end_of_text (r_eot),
        .o_state       (n_state),
        .o_status      (n_status),
        .o_value_type  (n_type)
    );

    assign proc_go = r_in_valid && (!r_eot || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || proc_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= jsv_pkg::SCAN_RESET;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (proc_go) begin
                r_state <= n_state;
            end
            if (proc_go && r_eot) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_text_byte;
            r_eot  <= i_end_of_text;
        end
        if (proc_go && r_eot) begin
            r_status <= n_status;
            r_type   <= n_type;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_value_type = r_type;

endmodule

`default_nettype wire

/* hw/rtl/jsv_scan.sv */
`default_nettype none

module jsv_scan (
    input  var jsv_pkg::t_scan_state i_state,
    input  wire logic [7:0]          i_text_byte,
    input  wire logic                i_end_of_text,
    output var jsv_pkg::t_scan_state o_state,
    output jsv_pkg::t_status         o_status,
    output jsv_pkg::t_value_type     o_value_type
);

    function automatic logic is_ws(input logic [7:0] c);
        return c inside {8'h20, 8'h09, 8'h0A, 8'h0D};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_exp(input logic [7:0] c);
        return c inside {"e", "E"};
    endfunction

    logic [7:0] c;
    logic [1:0] kind;
    logic [2:0] pos_inc;

    assign c       = i_text_byte;
    assign kind    = (i_state.lit_kind == jsv_pkg::TY_NUMBER) ? jsv_pkg::TY_NULL
                                                              : i_state.lit_kind;
    assign pos_inc = i_state.lit_pos + 3'd1;

    always_comb begin
        o_state      = i_state;
        o_status     = jsv_pkg::ST_OK;
        o_value_type = jsv_pkg::TY_NULL;
        if (i_end_of_text) begin
            case (i_state.phase)
                jsv_pkg::PH_LEAD: o_status = jsv_pkg::ST_EXPECT;
                jsv_pkg::PH_ZERO, jsv_pkg::PH_INT, jsv_pkg::PH_FRAC,
                jsv_pkg::PH_EXP_DIG: o_value_type = jsv_pkg::TY_NUMBER;
                jsv_pkg::PH_TRAIL: o_value_type = i_state.found_type;
                jsv_pkg::PH_ERROR: o_status = i_state.status;
                default: o_status = jsv_pkg::ST_INVALID;
            endcase
            if (o_status != jsv_pkg::ST_OK) begin
                o_value_type = jsv_pkg::TY_NULL;
            end
            o_state = jsv_pkg::SCAN_RESET;
        end else begin
            case (i_state.phase)
                jsv_pkg::PH_LEAD: begin
                    if (is_ws(c)) begin
                        o_state.phase = jsv_pkg::PH_LEAD;
                    end else if (c == "n" || c == "f" || c == "t") begin
                        o_state.phase    = jsv_pkg::PH_LITERAL;
                        o_state.lit_pos  = 3'd1;
                        o_state.lit_kind = (c == "n") ? jsv_pkg::TY_NULL
                                         : ((c == "f") ? jsv_pkg::TY_FALSE
                                                       : jsv_pkg::TY_TRUE);
                    end else if (c == "-") begin
                        o_state.phase = jsv_pkg::PH_MINUS;
                    end else if (c == "0") begin
                        o_state.phase = jsv_pkg::PH_ZERO;
                    end else if (is_digit(c)) begin
                        o_state.phase = jsv_pkg::PH_INT;
                    end else begin
                        o_state.phase  = jsv_pkg::PH_ERROR;
                        o_state.status = jsv_pkg::ST_INVALID;
                    end
                end
                jsv_pkg::PH_LITERAL: begin
                    if (i_state.lit_pos < jsv_pkg::lit_len(kind)
                            && c == jsv_pkg::lit_char(kind, i_state.lit_pos)) begin
                        o_state.lit_pos = pos_inc;
                        if (pos_inc >= jsv_pkg::lit_len(kind)) begin
                            o_state.found_type = jsv_pkg::t_value_type'(kind);
                            o_state.phase      = jsv_pkg::PH_TRAIL;
                        end
                    end else begin
                        o_state.phase  = jsv_pkg::PH_ERROR;
                        o_state.status = jsv_pkg::ST_INVALID;
                    end
                end
                jsv_pkg::PH_MINUS: begin
                    if (c == "0") begin
                        o_state.phase = jsv_pkg::PH_ZERO;
                    end else if (is_digit(c)) begin
                        o_state.phase = jsv_pkg::PH_INT;
                    end else begin
                        o_state.phase  = jsv_pkg::PH_ERROR;
                        o_state.status = jsv_pkg::ST_INVALID;
                    end
                end
                jsv_pkg::PH_ZERO, jsv_pkg::PH_INT, jsv_pkg::PH_FRAC,
                jsv_pkg::PH_EXP_DIG: begin
                    if (is_digit(c) && i_state.phase != jsv_pkg::PH_ZERO) begin
                        o_state.phase = i_state.phase;
                    end else if (c == "." && (i_state.phase == jsv_pkg::PH_ZERO
                            || i_state.phase == jsv_pkg::PH_INT)) begin
                        o_state.phase = jsv_pkg::PH_DOT;
                    end else if (is_exp(c) && i_state.phase != jsv_pkg::PH_EXP_DIG) begin
                        o_state.phase = jsv_pkg::PH_EXP;
                    end else if (is_ws(c)) begin
                        o_state.found_type = jsv_pkg::TY_NUMBER;
                        o_state.phase      = jsv_pkg::PH_TRAIL;
                    end else begin
                        o_state.phase  = jsv_pkg::PH_ERROR;
                        o_state.status = jsv_pkg::ST_NOT_SING;
                    end
                end
                jsv_pkg::PH_DOT: begin
                    if (is_digit(c)) begin
                        o_state.phase = jsv_pkg::PH_FRAC;
                    end else begin
                        o_state.phase  = jsv_pkg::PH_ERROR;
                        o_state.status = jsv_pkg::ST_INVALID;
                    end
                end
                jsv_pkg::PH_EXP: begin
                    if (c == "+" || c == "-") begin
                        o_state.phase = jsv_pkg::PH_EXP_SIGN;
                    end else if (is_digit(c)) begin
                        o_state.phase = jsv_pkg::PH_EXP_DIG;
                    end else begin
                        o_state.phase  = jsv_pkg::PH_ERROR;
                        o_state.status = jsv_pkg::ST_INVALID;
                    end
                end
                jsv_pkg::PH_EXP_SIGN: begin
                    if (is_digit(c)) begin
                        o_state.phase = jsv_pkg::PH_EXP_DIG;
                    end else begin
                        o_state.phase  = jsv_pkg::PH_ERROR;
                        o_state.status = jsv_pkg::ST_INVALID;
                    end
                end
                jsv_pkg::PH_TRAIL: begin
                    if (!is_ws(c)) begin
                        o_state.phase  = jsv_pkg::PH_ERROR;
                        o_state.status = jsv_pkg::ST_NOT_SING;
                    end
                end
                default: begin
                    o_state = i_state;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/jsv_checker.sv */
`default_nettype none

module jsv_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_ready,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [1:0] o_status,
    input wire logic [1:0] o_value_type
);

    // a waiting result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_value_type))
        else $error("result changed while stalled");

    // errors carry the null type
    a_err_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != jsv_pkg::ST_OK |-> o_value_type == jsv_pkg::TY_NULL)
        else $error("error result with non-null type");

    // an empty output register never holds back the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

endmodule

bind json_scalar_validator_unit jsv_checker u_jsv_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_status     (o_status),
    .o_value_type (o_value_type)
);

`default_nettype wire
